[src/arp_pkg.sv]
// Shared types, codes and constants for the ARP cache and responder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package arp_pkg;

    // Cache depth default and placement limits
    localparam int ENTRIES_DEFAULT = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Protocol constants
    localparam logic [10:0] MIN_PACKET_LEN = 11'd28;
    localparam logic [15:0] OP_REQUEST     = 16'h0001;
    localparam logic [31:0] LIFETIME_RESET = 32'd300;
    localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

    // Stream widths
    localparam int IN_TDATA_W  = 176;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 176;
    localparam int OUT_TUSER_W = 5;

    // Input request kinds (carried on tuser)
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_PACKET = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_HIT       = 3'd0;
    localparam logic [2:0] STAT_MISS_REQ  = 3'd1;
    localparam logic [2:0] STAT_MISS_DOWN = 3'd2;
    localparam logic [2:0] STAT_STORED    = 3'd3;
    localparam logic [2:0] STAT_IGNORED   = 3'd4;
    localparam logic [2:0] STAT_TICK      = 3'd5;

    // Frame kinds
    localparam logic [1:0] FK_NONE    = 2'd0;
    localparam logic [1:0] FK_REQUEST = 2'd1;
    localparam logic [1:0] FK_REPLY   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_IP   = 2'd0;
    localparam logic [1:0] CFG_OWN_MAC  = 2'd1;
    localparam logic [1:0] CFG_LIFETIME = 2'd2;
    localparam logic [1:0] CFG_LINK_UP  = 2'd3;

    // Classified command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_STORE,
        CMD_IGNORE,
        CMD_TICK
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        reply;
    } cmd_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac;
        logic [1:0]  fkind;
        logic [47:0] dmac;
        logic [47:0] tmac;
        logic [31:0] tip;
    } res_t;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [31:0] lifetime;
        logic        link_up;
    } cfg_t;

endpackage

`default_nettype wire

[src/arp_front.sv]
// Front end: unpacks the input stream and classifies each request into a command.
// Depends on arp_pkg; feeds arp_queue.
`default_nettype none

module arp_front
    import arp_pkg::*;
(
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire cfg_t                   cfg,
    input  wire logic                   q_full,
    output logic                        q_push,
    output cmd_t                        q_cmd
);

    logic [1:0]  req_type;
    logic [31:0] query_ip;
    logic [10:0] packet_length;
    logic [15:0] packet_opcode;
    logic [31:0] pkt_src_ip;
    logic [47:0] pkt_src_mac;
    logic [31:0] pkt_dst_ip;

    // Unpack fields
    assign req_type      = s_axis_tuser[1:0];
    assign query_ip      = s_axis_tdata[31:0];
    assign packet_length = s_axis_tdata[42:32];
    assign packet_opcode = s_axis_tdata[58:43];
    assign pkt_src_ip    = s_axis_tdata[90:59];
    assign pkt_src_mac   = s_axis_tdata[138:91];
    assign pkt_dst_ip    = s_axis_tdata[170:139];

    // Accept whenever the queue has room; drop the unused request kind
    assign s_axis_tready = ~q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready && (req_type != REQ_UNUSED);

    // Classify
    always_comb
    begin
        q_cmd.ip    = pkt_src_ip;
        q_cmd.mac   = pkt_src_mac;
        q_cmd.reply = (packet_opcode == OP_REQUEST) && (pkt_dst_ip == cfg.own_ip);
        case (req_type)
            REQ_LOOKUP:
            begin
                q_cmd.kind = CMD_LOOKUP;
                q_cmd.ip   = query_ip;
            end
            REQ_PACKET:
            begin
                q_cmd.kind = (packet_length < MIN_PACKET_LEN) ? CMD_IGNORE : CMD_STORE;
            end
            REQ_TICK:
            begin
                q_cmd.kind = CMD_TICK;
            end
            default:
            begin
                q_cmd.kind = CMD_IGNORE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/arp_queue.sv]
// Short command queue between the front end and the cache engine.
// Depends on arp_pkg for cmd_t and the queue depth.
`default_nettype none

module arp_queue
    import arp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/arp_back.sv]
// Cache engine: scans the entry memory one entry per cycle, updates the cache
// and the tick counter, and holds the result register. Depends on arp_pkg.
`default_nettype none

module arp_back
    import arp_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  issue_cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [IDX_W-1:0]  pend_idx_next;
    entry_t            rd_entry_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]       now_reg;
    logic [31:0]       now_next;
    res_t              res_reg;
    res_t              res_next;
    logic              out_valid_reg;
    res_t              out_reg;

    entry_t            entry_mem [ENTRIES];

    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_slot;
    entry_t            wr_entry;
    logic              load_out;

    logic              ent_valid;
    logic              ip_eq;
    logic [31:0]       age;
    logic              lookup_match;
    logic              store_match;
    logic              match;
    logic              last_entry;
    logic              scan_done;

    // Compare the entry read in the previous cycle
    assign ent_valid    = valid_reg[pend_idx_reg];
    assign ip_eq        = (rd_entry_reg.ip == cmd_reg.ip);
    assign age          = now_reg - rd_entry_reg.stamp;
    assign lookup_match = pend_reg && ent_valid && ip_eq && (age < cfg.lifetime);
    assign store_match  = pend_reg && (!ent_valid || ip_eq);
    assign match        = (cmd_reg.kind == CMD_LOOKUP) ? lookup_match : store_match;
    assign last_entry   = pend_reg && (pend_idx_reg == IDX_W'(ENTRIES - 1));
    assign scan_done    = match || last_entry;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if ((q_cmd.kind == CMD_LOOKUP) || (q_cmd.kind == CMD_STORE))
                    begin
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control strobes and datapath updates
    always_comb
    begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_slot        = match ? pend_idx_reg : '0;
        wr_entry.ip    = cmd_reg.ip;
        wr_entry.mac   = cmd_reg.mac;
        wr_entry.stamp = now_reg;
        load_out       = 1'b0;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop          = q_valid;
                issue_cnt_next = '0;
                if (q_valid)
                begin
                    res_next = '0;
                    if (q_cmd.kind == CMD_TICK)
                    begin
                        res_next.status = STAT_TICK;
                        now_next        = now_reg + 32'd1;
                    end
                    else
                    begin
                        res_next.status = STAT_IGNORED;
                    end
                end
            end
            BK_SCAN:
            begin
                // Issue the next read while checking the previous one
                rd_en = (issue_cnt_reg < CNT_W'(ENTRIES));
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    pend_next      = !scan_done;
                    pend_idx_next  = issue_cnt_reg[IDX_W-1:0];
                end
                if (scan_done)
                begin
                    res_next = '0;
                    if (cmd_reg.kind == CMD_LOOKUP)
                    begin
                        if (match)
                        begin
                            res_next.status = STAT_HIT;
                            res_next.mac    = rd_entry_reg.mac;
                        end
                        else if (cfg.link_up)
                        begin
                            res_next.status = STAT_MISS_REQ;
                            res_next.fkind  = FK_REQUEST;
                            res_next.dmac   = MAC_BROADCAST;
                            res_next.tip    = cmd_reg.ip;
                        end
                        else
                        begin
                            res_next.status = STAT_MISS_DOWN;
                        end
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        res_next.status = STAT_STORED;
                        if (cmd_reg.reply)
                        begin
                            res_next.fkind = FK_REPLY;
                            res_next.dmac  = cmd_reg.mac;
                            res_next.tmac  = cmd_reg.mac;
                            res_next.tip   = cmd_reg.ip;
                        end
                    end
                end
            end
            BK_EMIT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            now_reg       <= now_next;
            if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_slot] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

[src/arp_cache_and_responder.sv]
// ARP cache and responder top level: configuration registers, front end,
// command queue and cache engine. Depends on arp_pkg, arp_front, arp_queue, arp_back.
// A tick or an ignored packet passes from the queue through the result register to the
// output register; a lookup or stored packet first scans the entry memory one entry per
// cycle until a match or the last entry. A stalled result holds the engine.
// The engine takes one command at a time, only after emitting the last; the queue takes two items ahead.
// Reset: rst_n clears all entry valid bits and the tick counter at once; no sweep.
`default_nettype none

module arp_cache_and_responder
    import arp_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // tdata: query_ip[31:0], packet_length[42:32], packet_opcode[58:43],
    //        src_ip[90:59], src_mac[138:91], dst_ip[170:139], zero fill
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // tdata: resolved_mac[47:0], frame_dest_mac[95:48],
    //        frame_target_mac[143:96], frame_target_ip[175:144]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: status[2:0], frame_kind[4:3]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [47:0]            cfg_data
);

    logic [31:0] own_ip_reg;
    logic [31:0] lifetime_reg;
    logic        link_up_reg;
    cfg_t        cfg;
    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    cmd_t        q_pop_cmd;
    res_t        out_res;

    // Configuration writes; the sender MAC is not part of any result, so it is not held
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg   <= '0;
            lifetime_reg <= LIFETIME_RESET;
            link_up_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                CFG_LIFETIME: lifetime_reg <= cfg_data[31:0];
                CFG_LINK_UP:  link_up_reg  <= cfg_data[0];
                default:      own_ip_reg   <= own_ip_reg;
            endcase
        end
    end

    assign cfg.own_ip   = own_ip_reg;
    assign cfg.lifetime = lifetime_reg;
    assign cfg.link_up  = link_up_reg;

    arp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    arp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (q_pop_cmd)
    );

    arp_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_not_empty),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result
    assign m_axis_tdata = {out_res.tip, out_res.tmac, out_res.dmac, out_res.mac};
    assign m_axis_tuser = {out_res.fkind, out_res.status};

`ifndef SYNTHESIS
    // A request frame only comes from a lookup miss with the link up
    a_request_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.fkind == FK_REQUEST)) |->
            ((out_res.status == STAT_MISS_REQ) && (out_res.dmac == MAC_BROADCAST)
             && (out_res.tmac == '0)))
        else $error("request frame without a lookup miss");

    // No frame means all frame fields are zero
    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.fkind == FK_NONE)) |->
            ((out_res.dmac == '0) && (out_res.tmac == '0) && (out_res.tip == '0)))
        else $error("frame fields set without a frame");

    // A MAC is only resolved on a hit
    a_mac_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.status != STAT_HIT)) |-> (out_res.mac == '0))
        else $error("resolved MAC on a non-hit result");

    // The queue never accepts a command while full
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command pushed into a full queue");
`endif

endmodule

`default_nettype wire
